@@ src/swm_pkg.sv @@
`timescale 1ns / 1ps

package swm_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int CFG_W        = 7;
  localparam int POS_W        = $clog2(2 * WINDOW_MAX);
  localparam int CNT_W        = $clog2(WINDOW_MAX + 1);

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_DROP,
    OP_STEP,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic                           valid;
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic [POS_W-1:0]               position;
  } cand_t;

  typedef struct packed {
    op_t                            op;
    logic                           shift;
    logic signed [SAMPLE_WIDTH-1:0] key;
    logic [POS_W-1:0]               pos;
    logic [CNT_W-1:0]               wsize;
  } cell_ctrl_t;

endpackage

@@ src/swm_cell.sv @@
`timescale 1ns / 1ps

module swm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  swm_pkg::cell_ctrl_t ctrl,
  input  swm_pkg::cand_t     right_cand,
  input  logic               left_alive,
  output swm_pkg::cand_t     cand,
  output logic               alive,
  output logic               expired
);

  logic                                    valid_r;
  logic                                    valid_nxt;
  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] value_r;
  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] value_nxt;
  logic [swm_pkg::POS_W-1:0]               position_r;
  logic [swm_pkg::POS_W-1:0]               position_nxt;
  logic [swm_pkg::POS_W-1:0]               age;
  swm_pkg::cand_t                          src;

  assign cand = '{valid: valid_r, value: value_r, position: position_r};

  assign age     = ctrl.pos - position_r;
  assign expired = valid_r && (age >= swm_pkg::POS_W'(ctrl.wsize));

  assign src   = ctrl.shift ? right_cand : cand;
  assign alive = src.valid && ($signed(src.value) > $signed(ctrl.key));

  always_comb begin
    valid_nxt    = valid_r;
    value_nxt    = value_r;
    position_nxt = position_r;
    unique case (ctrl.op)
      swm_pkg::OP_HOLD: begin
      end
      swm_pkg::OP_DROP: begin
        valid_nxt    = right_cand.valid;
        value_nxt    = right_cand.value;
        position_nxt = right_cand.position;
      end
      swm_pkg::OP_STEP: begin
        if (alive) begin
          valid_nxt    = 1'b1;
          value_nxt    = src.value;
          position_nxt = src.position;
        end else if (left_alive) begin
          // first free slot: new sample goes here
          valid_nxt    = 1'b1;
          value_nxt    = ctrl.key;
          position_nxt = ctrl.pos;
        end else begin
          valid_nxt = 1'b0;
        end
      end
      swm_pkg::OP_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    position_r <= position_nxt;
  end

endmodule

@@ src/sliding_window_maximum.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       input      in_valid/in_ready     in_sample_value, in_end_of_stream
// out      output     out_valid/out_ready   out_window_max, out_last_window
// cfg      input      cfg_valid/cfg_ready   cfg_window_size
//
// One item per cycle while in_ready is high; a row of WINDOW_MAX candidate cells updates in the cycle
// the item is accepted and the result lands in the output register.
// Each further stale candidate at the head (only after window_size shrinks)
// is dropped by a shift of the row, one cell shift per cycle, before the item is taken.
// Synchronous active-low reset empties the row; window_size resets to 3.
// A full output register that is not drained holds off in_ready.

module sliding_window_maximum (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] in_sample_value,
  input  logic                                    in_end_of_stream,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [swm_pkg::SAMPLE_WIDTH-1:0] out_window_max,
  output logic                                    out_last_window,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]               cfg_window_size
);

  localparam int WM = swm_pkg::WINDOW_MAX;

  logic [swm_pkg::CFG_W-1:0]               window_size_r;
  logic [swm_pkg::CNT_W-1:0]               fill_r;
  logic [swm_pkg::CNT_W-1:0]               fill_nxt;
  logic [swm_pkg::POS_W-1:0]               pos_r;
  logic                                    out_valid_r;
  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] out_max_r;
  logic                                    out_last_r;

  logic [swm_pkg::CNT_W-1:0]               w_eff;
  logic                                    two_exp;
  logic                                    out_free;
  logic                                    accept;
  logic                                    produce;
  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] front;
  swm_pkg::cell_ctrl_t                     ctrl;

  swm_pkg::cand_t cand    [0:WM];
  logic [WM-1:0]  expired;
  logic [WM-1:0]  alive;

  assign cand[WM] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < WM; gi++) begin : g_cell
      logic left_alive;
      if (gi == 0) begin : g_head
        assign left_alive = 1'b1;
      end else begin : g_body
        assign left_alive = alive[gi-1];
      end
      swm_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .right_cand (cand[gi+1]),
        .left_alive (left_alive),
        .cand       (cand[gi]),
        .alive      (alive[gi]),
        .expired    (expired[gi])
      );
    end
  endgenerate

  always_comb begin
    if (window_size_r == '0) begin
      w_eff = swm_pkg::CNT_W'(1);
    end else if (window_size_r > swm_pkg::CFG_W'(WM)) begin
      w_eff = swm_pkg::CNT_W'(WM);
    end else begin
      w_eff = swm_pkg::CNT_W'(window_size_r);
    end
  end

  assign two_exp  = expired[0] && expired[1];
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = out_free && !two_exp;
  assign accept   = in_valid && in_ready;

  assign fill_nxt = (fill_r < swm_pkg::CNT_W'(WM)) ? fill_r + 1'b1 : fill_r;
  assign produce  = fill_nxt >= w_eff;

  always_comb begin
    ctrl.shift = expired[0];
    ctrl.key   = in_sample_value;
    ctrl.pos   = pos_r;
    ctrl.wsize = w_eff;
    if (accept) begin
      ctrl.op = in_end_of_stream ? swm_pkg::OP_CLEAR : swm_pkg::OP_STEP;
    end else if (in_valid && two_exp) begin
      ctrl.op = swm_pkg::OP_DROP;
    end else begin
      ctrl.op = swm_pkg::OP_HOLD;
    end
  end

  // head after the step: surviving oldest candidate, else the new sample
  always_comb begin
    if (!alive[0]) begin
      front = in_sample_value;
    end else if (expired[0]) begin
      front = cand[1].value;
    end else begin
      front = cand[0].value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= swm_pkg::CFG_W'(3);
      fill_r        <= '0;
      pos_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_size_r <= cfg_window_size;
      end
      if (accept) begin
        if (in_end_of_stream) begin
          fill_r <= '0;
          pos_r  <= '0;
        end else begin
          fill_r <= fill_nxt;
          pos_r  <= pos_r + 1'b1;
        end
      end
      if (out_free) begin
        out_valid_r <= accept && produce;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      out_max_r  <= front;
      out_last_r <= in_end_of_stream;
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_window_max  = out_max_r;
  assign out_last_window = out_last_r;

  a_packed_row: assert property (@(posedge clk) disable iff (!rst_n)
    cand[1].valid |-> cand[0].valid)
    else $error("candidate row not packed from the head");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_stream |=> !cand[0].valid && fill_r == '0 && pos_r == '0)
    else $error("end of stream did not empty the row");

  a_pos_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < swm_pkg::CNT_W'(WM) |-> swm_pkg::CNT_W'(pos_r) == fill_r)
    else $error("position counter out of step with fill count");

  a_head_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> expired[WM-1:1] == '0)
    else $error("item taken with more than one stale candidate at the head");

endmodule
